FILE: sv/nitb_pkg.sv
package nitb_pkg;

    localparam int NITB_NUM_TIMERS = 16;

    localparam int IDX_W   = 4;
    localparam int TIME_W  = 63;
    localparam int DEPTH_W = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};

    // opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_STOP   = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_ROLLBACK = 2'd2;
    localparam logic [1:0] ST_REGRESS  = 2'd3;

    // item classes decided by the front end
    localparam logic [2:0] K_START     = 3'd0;
    localparam logic [2:0] K_STOP      = 3'd1;
    localparam logic [2:0] K_REPORT    = 3'd2;
    localparam logic [2:0] K_IGNORE    = 3'd3;
    localparam logic [2:0] K_OUT_RANGE = 3'd4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // 63-bit sum, saturated
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

FILE: sv/nested_interval_timer_bank_top.sv
// A result is registered through the queue, the read stage and the execute stage after its
// transfer is taken. The back end reads an item and then executes it, and takes no new
// item from the queue while one is in execute.
// A two-entry queue parts front and back; busy rises while it is full.
// Reset (synchronous, active low) empties the queue, clears all timers to zero
// through per-entry valid bits and holds busy high. The receiver cannot stall.
module nested_interval_timer_bank_top
    import nitb_pkg::*;
#(
    parameter int NUM_TIMERS = NITB_NUM_TIMERS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_opcode,
    input  logic [IDX_W-1:0]     i_timer_index,
    input  logic [TIME_W-1:0]    i_now,
    input  logic                 i_suppress,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [TIME_W-1:0]    o_total_time,
    output logic [DEPTH_W-1:0]   o_nest_depth
);

    t_item   front_item;
    t_item   head_item;
    t_q_ctrl q_ctrl;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // Front end: take the transfer and classify it (out of range, suppressed,
    // undefined opcode, or a real start, stop or report).
    nitb_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .start         (start),
        .i_opcode      (i_opcode),
        .i_timer_index (i_timer_index),
        .i_now         (i_now),
        .i_suppress    (i_suppress),
        .i_q_stat      (q_stat),
        .i_rst_n       (i_rst_n),
        .o_busy        (busy),
        .o_push        (push),
        .o_item        (front_item)
    );

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    // Queue: decouple acceptance from execution.
    nitb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_item  (front_item),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    // Back end: read the timer entry and its elapsed time into the execute registers,
    // then accumulate, compare, write back and register the result with its strobe.
    nitb_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_total_time (o_total_time),
        .o_nest_depth (o_nest_depth)
    );

endmodule

FILE: sv/nitb_front.sv
module nitb_front
    import nitb_pkg::*;
#(
    parameter int NUM_TIMERS = NITB_NUM_TIMERS
) (
    input  logic                start,
    input  logic [1:0]          i_opcode,
    input  logic [IDX_W-1:0]    i_timer_index,
    input  logic [TIME_W-1:0]   i_now,
    input  logic                i_suppress,
    input  t_q_stat             i_q_stat,
    input  logic                i_rst_n,
    output logic                o_busy,
    output logic                o_push,
    output t_item               o_item
);

    logic in_range;

    // hold off transfers while the queue is full or reset is asserted
    assign o_busy   = i_q_stat.full | ~i_rst_n;
    assign o_push   = start & ~o_busy;
    assign in_range = 32'(i_timer_index) < NUM_TIMERS;

    always_comb begin
        o_item.idx = i_timer_index;
        o_item.now = i_now;
        if (!in_range) begin
            o_item.kind = K_OUT_RANGE;
        end else begin
            case (i_opcode)
                OP_REPORT: o_item.kind = K_REPORT;
                OP_START:  o_item.kind = i_suppress ? K_IGNORE : K_START;
                OP_STOP:   o_item.kind = i_suppress ? K_IGNORE : K_STOP;
                default:   o_item.kind = K_IGNORE;
            endcase
        end
    end

endmodule

FILE: sv/nitb_queue.sv
module nitb_queue
    import nitb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_ctrl i_ctrl,
    input  t_item   i_item,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_item       = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_ctrl.push && i_ctrl.pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.push) begin
                r_wp <= ~r_wp;
            end
            if (i_ctrl.pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

FILE: sv/nitb_back.sv
module nitb_back
    import nitb_pkg::*;
#(
    parameter int NUM_TIMERS = NITB_NUM_TIMERS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_item                i_item,
    input  t_q_stat              i_q_stat,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [TIME_W-1:0]    o_total_time,
    output logic [DEPTH_W-1:0]   o_nest_depth
);

    localparam int DEPTH = (NUM_TIMERS < (1 << IDX_W)) ? NUM_TIMERS : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // timer table
    logic [DEPTH-1:0]   r_vld;
    logic [DEPTH_W-1:0] r_depth [DEPTH];
    logic [TIME_W-1:0]  r_start [DEPTH];
    logic [TIME_W-1:0]  r_acc   [DEPTH];
    logic [TIME_W-1:0]  r_last  [DEPTH];

    // execute stage
    logic                r_v;
    logic [2:0]          r_kind;
    logic [AW-1:0]       r_idx;
    logic [TIME_W-1:0]   r_now;
    logic [DEPTH_W-1:0]  r_e_depth;
    logic [TIME_W-1:0]   r_e_start;
    logic [TIME_W-1:0]   r_e_acc;
    logic [TIME_W-1:0]   r_e_last;
    logic [TIME_W-1:0]   r_elapsed;
    logic                r_before;

    logic [AW-1:0]       rd_idx;
    logic                rd_vld;
    logic [TIME_W-1:0]   rd_start;
    logic [TIME_W:0]     diff;

    logic [TIME_W-1:0]   sum;
    logic [1:0]          n_status;
    logic [TIME_W-1:0]   n_total;
    logic [DEPTH_W-1:0]  n_depth;
    logic [TIME_W-1:0]   n_start;
    logic [TIME_W-1:0]   n_acc;
    logic [TIME_W-1:0]   n_last;
    logic                n_write;

    assign o_pop    = ~r_v & ~i_q_stat.empty;
    assign rd_idx   = i_item.idx[AW-1:0];
    assign rd_vld   = r_vld[rd_idx];
    assign rd_start = rd_vld ? r_start[rd_idx] : '0;
    assign diff     = {1'b0, i_item.now} - {1'b0, rd_start};
    assign sum      = sat_add(r_e_acc, r_elapsed);

    always_comb begin
        n_status = ST_OK;
        n_total  = r_e_acc;
        n_depth  = r_e_depth;
        n_start  = r_e_start;
        n_acc    = r_e_acc;
        n_last   = r_e_last;
        n_write  = 1'b1;
        case (r_kind)
            K_START: begin
                if (r_e_depth == '0) begin
                    n_start = r_now;
                end
                if (r_e_depth != DEPTH_MAX) begin
                    n_depth = r_e_depth + DEPTH_W'(1);
                end
            end
            K_STOP: begin
                if (r_e_depth == '0) begin
                    n_status = ST_IGNORED;
                end else if (r_e_depth == DEPTH_W'(1)) begin
                    n_depth = '0;
                    if (r_before) begin
                        n_status = ST_ROLLBACK;
                    end else begin
                        n_acc   = sum;
                        n_total = sum;
                    end
                end else begin
                    n_depth = r_e_depth - DEPTH_W'(1);
                end
            end
            K_REPORT: begin
                n_total = (r_e_depth != '0) ? sum : r_e_acc;
                if (n_total < r_e_last) begin
                    n_status = ST_REGRESS;
                end
                n_last = n_total;
            end
            K_OUT_RANGE: begin
                n_status = ST_IGNORED;
                n_total  = '0;
                n_depth  = '0;
                n_write  = 1'b0;
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            o_valid <= 1'b0;
            r_vld   <= '0;
        end else begin
            o_valid <= r_v;
            if (r_v) begin
                r_v <= 1'b0;
                if (n_write) begin
                    r_vld[r_idx] <= 1'b1;
                end
            end else if (o_pop) begin
                r_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_item.kind;
            r_idx     <= rd_idx;
            r_now     <= i_item.now;
            r_e_depth <= rd_vld ? r_depth[rd_idx] : '0;
            r_e_start <= rd_start;
            r_e_acc   <= rd_vld ? r_acc[rd_idx] : '0;
            r_e_last  <= rd_vld ? r_last[rd_idx] : '0;
            r_before  <= diff[TIME_W];
            r_elapsed <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
        end
        if (r_v) begin
            o_status     <= n_status;
            o_total_time <= n_total;
            o_nest_depth <= n_depth;
            if (n_write) begin
                r_depth[r_idx] <= n_depth;
                r_start[r_idx] <= n_start;
                r_acc[r_idx]   <= n_acc;
                r_last[r_idx]  <= n_last;
            end
        end
    end

endmodule

FILE: sv/nitb_checker.sv
module nitb_assertions
    import nitb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                busy,
    input logic                o_valid,
    input logic [1:0]          o_status,
    input logic [DEPTH_W-1:0]  o_nest_depth
);

    // the back end never strobes in back-to-back cycles
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe on consecutive cycles");

    // reset drops the strobe
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // no transfer is taken during reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |-> busy)
        else $error("busy low during reset");

    // a rollback only comes from the last stop, so the depth is back at zero
    a_rollback_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ROLLBACK) |-> (o_nest_depth == '0))
        else $error("rollback with nonzero depth");

endmodule

bind nested_interval_timer_bank_top nitb_assertions u_nitb_assertions (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_nest_depth (o_nest_depth)
);

FILE: tb/nitb_checker.sv
`timescale 1ns / 1ps

module nitb_checker
    import nitb_pkg::*;
#(
    parameter int NUM_TIMERS = NITB_NUM_TIMERS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [1:0]           i_opcode,
    input  logic [IDX_W-1:0]     i_timer_index,
    input  logic [TIME_W-1:0]    i_now,
    input  logic                 i_suppress,
    input  logic                 i_res_valid,
    input  logic [1:0]           i_status,
    input  logic [TIME_W-1:0]    i_total_time,
    input  logic [DEPTH_W-1:0]   i_nest_depth,
    output int                   o_fail_count = 0,
    output int                   o_pending = 0
);

    typedef struct packed {
        logic [1:0]         status;
        logic [TIME_W-1:0]  total;
        logic [DEPTH_W-1:0] depth;
    } t_timer_result;

    logic [DEPTH_W-1:0] depth_tab [NUM_TIMERS];
    logic [TIME_W-1:0]  begin_tab [NUM_TIMERS];
    logic [TIME_W-1:0]  accum_tab [NUM_TIMERS];
    logic [TIME_W-1:0]  shown_tab [NUM_TIMERS];

    t_timer_result awaited_results [$];
    t_timer_result due;
    int            mismatches;

    function automatic logic [TIME_W-1:0] clamp_sum(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        if (wide > {1'b0, TIME_MAX})
            return TIME_MAX;
        return wide[TIME_W-1:0];
    endfunction

    // work out the result of one timer operation and advance the timer copy
    task automatic apply_timer_op(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                  input logic [TIME_W-1:0] now, input logic sup);
        t_timer_result r;
        int t;
        r.status = ST_OK;
        r.total  = '0;
        r.depth  = '0;
        if (int'(idx) >= NUM_TIMERS) begin
            r.status = ST_IGNORED;
        end else begin
            t = int'(idx);
            if (op == OP_REPORT) begin
                r.total = accum_tab[t];
                if (depth_tab[t] != '0 && now >= begin_tab[t])
                    r.total = clamp_sum(r.total, now - begin_tab[t]);
                if (r.total < shown_tab[t])
                    r.status = ST_REGRESS;
                shown_tab[t] = r.total;
            end else if (sup || op > OP_REPORT) begin
                r.status = ST_IGNORED;
                r.total  = accum_tab[t];
            end else if (op == OP_START) begin
                if (depth_tab[t] == '0)
                    begin_tab[t] = now;
                if (depth_tab[t] != DEPTH_MAX)
                    depth_tab[t] = depth_tab[t] + DEPTH_W'(1);
                r.total = accum_tab[t];
            end else begin
                if (depth_tab[t] == '0) begin
                    r.status = ST_IGNORED;
                end else if (depth_tab[t] == DEPTH_W'(1)) begin
                    depth_tab[t] = '0;
                    if (now < begin_tab[t])
                        r.status = ST_ROLLBACK;
                    else
                        accum_tab[t] = clamp_sum(accum_tab[t], now - begin_tab[t]);
                end else begin
                    depth_tab[t] = depth_tab[t] - DEPTH_W'(1);
                end
                r.total = accum_tab[t];
            end
            r.depth = depth_tab[t];
        end
        awaited_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                depth_tab[k] = '0;
                begin_tab[k] = '0;
                accum_tab[k] = '0;
                shown_tab[k] = '0;
            end
            awaited_results.delete();
        end else begin
            mismatches = 0;
            if (i_start && !i_busy)
                apply_timer_op(i_opcode, i_timer_index, i_now, i_suppress);
            if (i_res_valid) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, i_status, i_total_time, i_nest_depth);
                    mismatches = mismatches + 1;
                end else begin
                    due = awaited_results.pop_front();
                    if (i_status !== due.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, due.status, i_status);
                        mismatches = mismatches + 1;
                    end
                    if (i_total_time !== due.total) begin
                        $display("%0t: total_time mismatch, expected %0d, actual %0d",
                                 $time, due.total, i_total_time);
                        mismatches = mismatches + 1;
                    end
                    if (i_nest_depth !== due.depth) begin
                        $display("%0t: nest_depth mismatch, expected %0d, actual %0d",
                                 $time, due.depth, i_nest_depth);
                        mismatches = mismatches + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + mismatches;
        end
        o_pending <= awaited_results.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nitb_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int CALM_ITEMS     = 200;    // tail of the run with no idling
    localparam int SETTLE_CYCLES  = 10;
    localparam int TIMEOUT_CYCLES = 800000;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_opcode = OP_START;
    logic [IDX_W-1:0]     i_timer_index = '0;
    logic [TIME_W-1:0]    i_now = '0;
    logic                 i_suppress = 1'b0;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [TIME_W-1:0]    o_total_time;
    logic [DEPTH_W-1:0]   o_nest_depth;

    int fail_count;
    int pending_count;

    // wall clock for well-formed interval sequences
    logic [TIME_W-1:0] wall_clock;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    nested_interval_timer_bank_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_timer_index (i_timer_index),
        .i_now         (i_now),
        .i_suppress    (i_suppress),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_total_time  (o_total_time),
        .o_nest_depth  (o_nest_depth)
    );

    nitb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_opcode      (i_opcode),
        .i_timer_index (i_timer_index),
        .i_now         (i_now),
        .i_suppress    (i_suppress),
        .i_res_valid   (o_valid),
        .i_status      (o_status),
        .i_total_time  (o_total_time),
        .i_nest_depth  (o_nest_depth),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Present one item and hold it until the block takes the transfer.
    // busy is sampled before the edge's updates land, so the edge we stop
    // on is exactly the one that accepted the item.
    task automatic send_item(input logic [1:0] op, input int idx,
                             input logic [TIME_W-1:0] now, input logic sup);
        start         <= 1'b1;
        i_opcode      <= op;
        i_timer_index <= IDX_W'(idx);
        i_now         <= now;
        i_suppress    <= sup;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Drop start for a burst of idle cycles.
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop start and hold until every predicted result has come back.
    // The checker's count is registered, so step past an edge before looking.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] any_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Pick a time stamp: mostly the advancing wall clock, with some noise
    // (arbitrary stamps, steps backwards, stamps near the top of the range).
    function automatic logic [TIME_W-1:0] pick_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return wall_clock;
        if (roll < 88)
            return any_time();
        if (roll < 94)
            return wall_clock - TIME_W'($urandom_range(0, 5000));
        return TIME_MAX - TIME_W'($urandom_range(0, 1000));
    endfunction

    initial begin
        logic [1:0] op;
        int roll;
        int idx;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: nesting, reports, the ignored cases, rollback,
        // regression and saturation of the sum.
        send_item(OP_REPORT, 0, '0, 1'b0);          // fresh timer reads zero
        send_item(OP_START,  0, 100, 1'b0);
        send_item(OP_START,  0, 200, 1'b0);         // nested: no new latch
        send_item(OP_REPORT, 0, 350, 1'b0);         // running total 250
        send_item(OP_STOP,   0, 400, 1'b0);
        send_item(OP_STOP,   0, 600, 1'b0);         // last stop closes 500
        send_item(OP_STOP,   0, 700, 1'b0);         // stop at depth zero
        send_item(OP_START,  0, 800, 1'b1);         // suppressed start
        send_item(OP_STOP,   0, 900, 1'b1);         // suppressed stop
        send_item(OP_UNDEFINED, 0, 950, 1'b0);      // undefined opcode
        send_item(OP_REPORT, 0, '0, 1'b1);          // suppress leaves report alone
        send_item(OP_START,  1, 1000, 1'b0);
        send_item(OP_REPORT, 1, 5000, 1'b0);
        send_item(OP_REPORT, 1, 500, 1'b0);         // before start: regression
        send_item(OP_STOP,   1, 100, 1'b0);         // before start: rollback
        send_item(OP_START,  2, '0, 1'b0);
        send_item(OP_STOP,   2, TIME_MAX, 1'b0);    // total at the ceiling
        send_item(OP_START,  2, '0, 1'b0);
        send_item(OP_REPORT, 2, TIME_MAX, 1'b0);    // running sum saturates
        send_item(OP_STOP,   2, 1, 1'b0);           // closed sum saturates
        send_item(OP_START,  3, TIME_MAX, 1'b0);
        send_item(OP_STOP,   3, TIME_MAX, 1'b0);    // zero-length interval
        send_item(OP_REPORT, 3, '0, 1'b0);

        // Pause the sender until the bank has answered everything.
        drain_results();

        // Nest one timer a few levels deep, then unwind part of the way.
        repeat (4)
            send_item(OP_START, 15, 2000, 1'b0);
        send_item(OP_REPORT, 15, 3000, 1'b0);
        repeat (3)
            send_item(OP_STOP, 15, 4000, 1'b0);
        send_item(OP_REPORT, 15, 5000, 1'b0);

        // Random part: mostly well-formed start/stop nesting on a few busy
        // timers with an advancing clock, the rest noise.
        wall_clock = 1000000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            wall_clock = wall_clock + TIME_W'($urandom_range(0, 2000));
            roll = $urandom_range(0, 99);
            if (roll < 38)
                op = OP_START;
            else if (roll < 75)
                op = OP_STOP;
            else if (roll < 96)
                op = OP_REPORT;
            else
                op = OP_UNDEFINED;
            idx = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            send_item(op, idx, pick_time(), $urandom_range(0, 11) == 0);

            if (n == RANDOM_ITEMS / 2)
                drain_results();
            else if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 9));
        end

        // Let the last results through, then give the verdict.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
